>>> rtl/moae_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package moae_pkg;

	localparam int WORD_W     = 32;
	localparam int DATA_DEPTH = 256;
	localparam int ADDR_W     = $clog2(DATA_DEPTH);
	localparam int STEP_W     = $clog2(WORD_W);
	localparam int ITEM_ADDR_W = 8;
	localparam int OPC_W      = 4;
	localparam int FIELD_W    = 4;

	localparam int OPC_LSB  = 28;
	localparam int SRCA_LSB = 24;
	localparam int REGA_LSB = 20;
	localparam int SRCB_LSB = 16;
	localparam int REGB_LSB = 12;

	localparam logic [1:0] OP_EXEC  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [OPC_W-1:0] OPC_ADD = 4'd1;
	localparam logic [OPC_W-1:0] OPC_SUB = 4'd2;
	localparam logic [OPC_W-1:0] OPC_MUL = 4'd3;
	localparam logic [OPC_W-1:0] OPC_DIV = 4'd4;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
	localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

	typedef logic [(1 << ITEM_ADDR_W)-1:0][ADDR_W-1:0] wrap_table_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_ctl_t;

	typedef struct packed {
		logic             start;
		logic [OPC_W-1:0] opcode;
	} alu_ctl_t;

	function automatic wrap_table_t build_wrap_table();
		wrap_table_t t;
		for (int i = 0; i < (1 << ITEM_ADDR_W); i++) begin
			t[i] = ADDR_W'(i % DATA_DEPTH);
		end
		return t;
	endfunction

	localparam wrap_table_t WRAP_TABLE = build_wrap_table();

	function automatic logic [ADDR_W-1:0] wrap_addr(logic [ITEM_ADDR_W-1:0] a);
		return WRAP_TABLE[a];
	endfunction

endpackage
`default_nettype wire

>>> rtl/moae_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface moae_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] instruction;
	logic [7:0]  mem_address;
	logic [31:0] write_data;

	modport source (
		output valid, operation, instruction, mem_address, write_data,
		input  ready
	);
	modport sink (
		input  valid, operation, instruction, mem_address, write_data,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/moae_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface moae_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_value;
	logic        stored;
	logic [7:0]  store_address;
	logic [1:0]  status;

	modport source (
		output valid, result_value, stored, store_address, status,
		input  ready
	);
	modport sink (
		input  valid, result_value, stored, store_address, status,
		output ready
	);
endinterface
`default_nettype wire

>>> rtl/moae_data_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module moae_data_mem (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire moae_pkg::mem_ctl_t                   ctl,
	input  wire logic [moae_pkg::WORD_W-1:0]          wr_data,
	output logic      [moae_pkg::WORD_W-1:0]          rd_data
);

	logic [moae_pkg::WORD_W-1:0] mem [moae_pkg::DATA_DEPTH];
	logic [moae_pkg::DATA_DEPTH-1:0] valid_q;
	logic [moae_pkg::WORD_W-1:0] rd_data_q;
	logic                        rd_valid_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem[ctl.rd_addr];
		end
	end

	// never-written words read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[ctl.wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[ctl.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

>>> rtl/moae_serial_alu.sv
`timescale 1ns / 1ps
`default_nettype none
module moae_serial_alu (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire moae_pkg::alu_ctl_t                   ctl,
	input  wire logic [moae_pkg::WORD_W-1:0]          a,
	input  wire logic [moae_pkg::WORD_W-1:0]          b,
	output logic                                      done,
	output logic      [moae_pkg::WORD_W-1:0]          result
);

	localparam int W = moae_pkg::WORD_W;
	localparam logic [moae_pkg::STEP_W-1:0] LAST_STEP = moae_pkg::STEP_W'(W - 1);

	logic [W-1:0]                x_q;
	logic [W-1:0]                y_q;
	logic [W-1:0]                acc_q;
	logic                        carry_q;
	logic [moae_pkg::OPC_W-1:0]  opc_q;
	logic [moae_pkg::STEP_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic       y_bit;
	logic       sum_bit;
	logic       carry_nxt;
	logic [W:0] rem_shift;
	logic [W:0] rem_diff;
	logic       rem_ge;

	always_comb begin
		y_bit     = (opc_q == moae_pkg::OPC_SUB) ? ~y_q[0] : y_q[0];
		sum_bit   = x_q[0] ^ y_bit ^ carry_q;
		carry_nxt = (x_q[0] & y_bit) | (x_q[0] & carry_q) | (y_bit & carry_q);
		rem_shift = {acc_q, x_q[W-1]};
		rem_diff  = rem_shift - {1'b0, y_q};
		rem_ge    = rem_shift >= {1'b0, y_q};
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q     <= a;
			y_q     <= b;
			acc_q   <= '0;
			carry_q <= (ctl.opcode == moae_pkg::OPC_SUB);
			opc_q   <= ctl.opcode;
		end else if (busy_q) begin
			case (opc_q)
				moae_pkg::OPC_ADD, moae_pkg::OPC_SUB: begin
					acc_q   <= {sum_bit, acc_q[W-1:1]};
					x_q     <= x_q >> 1;
					y_q     <= y_q >> 1;
					carry_q <= carry_nxt;
				end
				moae_pkg::OPC_MUL: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= x_q << 1;
					y_q <= y_q >> 1;
				end
				default: begin
					acc_q <= rem_ge ? rem_diff[W-1:0] : rem_shift[W-1:0];
					x_q   <= {x_q[W-2:0], rem_ge};
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done   = done_q;
	assign result = (opc_q == moae_pkg::OPC_DIV) ? x_q : acc_q;

endmodule
`default_nettype wire

>>> rtl/memory_operand_alu_executor.sv
// From transfer in to result valid: a direct write or an unknown operation or opcode
// goes straight to the output state, a direct read passes through one memory read, and an
// instruction reads its operands (once with equal register indices, else twice) and then
// waits for the 32-step bit-serial ALU, which sets the pace. One item at a time: the next
// transfer in can follow in the cycle after the result is loaded into the output register.
// Reset (arst_n, asynchronous, active low) empties the output and makes all data words read as zero.
`timescale 1ns / 1ps
`default_nettype none
module memory_operand_alu_executor (
	input  wire logic  clk,
	input  wire logic  arst_n,
	moae_in_if.sink    cmd,
	moae_out_if.source rsp
);

	localparam int W = moae_pkg::WORD_W;
	localparam int AW = moae_pkg::ADDR_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDB  = 3'd1;
	localparam logic [2:0] S_RDA  = 3'd2;
	localparam logic [2:0] S_RUN  = 3'd3;
	localparam logic [2:0] S_RDW  = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q;
	logic       accept;

	logic [moae_pkg::OPC_W-1:0] cmd_opc;
	logic                       cmd_opc_ok;
	logic [AW-1:0]              cmd_maddr;
	logic [AW-1:0]              cmd_srca;
	logic [AW-1:0]              cmd_srcb;
	logic [AW-1:0]              cmd_dest;

	logic [moae_pkg::OPC_W-1:0] opc_q;
	logic [AW-1:0]              srca_q;
	logic [AW-1:0]              dest_q;
	logic                       same_reg_q;
	logic [W-1:0]               b_q;
	logic                       dz_q;

	logic [W-1:0] res_value_q;
	logic         res_stored_q;
	logic [AW-1:0] res_addr_q;
	logic [1:0]   res_status_q;

	logic         out_valid_q;
	logic [W-1:0] out_value_q;
	logic         out_stored_q;
	logic [AW-1:0] out_addr_q;
	logic [1:0]   out_status_q;
	logic         out_load;

	moae_pkg::mem_ctl_t mem_ctl;
	moae_pkg::alu_ctl_t alu_ctl;
	logic [W-1:0]       mem_wr_data;
	logic [W-1:0]       mem_rd_data;
	logic [W-1:0]       alu_b;
	logic               alu_done;
	logic [W-1:0]       alu_result;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == S_IDLE);
	assign cmd_opc    = cmd.instruction[moae_pkg::OPC_LSB +: moae_pkg::OPC_W];
	assign cmd_opc_ok = cmd_opc inside {[moae_pkg::OPC_ADD:moae_pkg::OPC_DIV]};
	assign cmd_maddr  = moae_pkg::wrap_addr(cmd.mem_address);
	assign cmd_srca   = moae_pkg::wrap_addr(
		moae_pkg::ITEM_ADDR_W'(cmd.instruction[moae_pkg::SRCA_LSB +: moae_pkg::FIELD_W]));
	assign cmd_srcb   = moae_pkg::wrap_addr(
		moae_pkg::ITEM_ADDR_W'(cmd.instruction[moae_pkg::SRCB_LSB +: moae_pkg::FIELD_W]));
	assign cmd_dest   = moae_pkg::wrap_addr(cmd.instruction[moae_pkg::ITEM_ADDR_W-1:0]);

	always_comb begin
		mem_ctl         = '0;
		mem_ctl.rd_addr = cmd_maddr;
		mem_ctl.wr_addr = cmd_maddr;
		mem_wr_data     = cmd.write_data;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd.operation)
						moae_pkg::OP_WRITE: mem_ctl.wr_en = 1'b1;
						moae_pkg::OP_READ:  mem_ctl.rd_en = 1'b1;
						moae_pkg::OP_EXEC: begin
							mem_ctl.rd_en   = cmd_opc_ok;
							mem_ctl.rd_addr = cmd_srcb;
						end
						default: ;
					endcase
				end
			end
			S_RDB: begin
				mem_ctl.rd_en   = !same_reg_q;
				mem_ctl.rd_addr = srca_q;
			end
			S_RUN: begin
				mem_ctl.wr_en   = alu_done;
				mem_ctl.wr_addr = dest_q;
				mem_wr_data     = alu_result;
			end
			default: ;
		endcase
	end

	assign alu_ctl.start  = ((state_q == S_RDB) && same_reg_q) || (state_q == S_RDA);
	assign alu_ctl.opcode = opc_q;
	assign alu_b          = (state_q == S_RDB) ? mem_rd_data : b_q;

	moae_data_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mem_ctl),
		.wr_data (mem_wr_data),
		.rd_data (mem_rd_data)
	);

	moae_serial_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a      (mem_rd_data),
		.b      (alu_b),
		.done   (alu_done),
		.result (alu_result)
	);

	assign out_load = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.operation)
							moae_pkg::OP_READ: state_q <= S_RDW;
							moae_pkg::OP_EXEC: state_q <= cmd_opc_ok ? S_RDB : S_OUT;
							default:           state_q <= S_OUT;
						endcase
					end
				end
				S_RDB:   state_q <= same_reg_q ? S_RUN : S_RDA;
				S_RDA:   state_q <= S_RUN;
				S_RUN: begin
					if (alu_done) begin
						state_q <= S_OUT;
					end
				end
				S_RDW:   state_q <= S_OUT;
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opc_q        <= cmd_opc;
			srca_q       <= cmd_srca;
			dest_q       <= cmd_dest;
			same_reg_q   <= cmd.instruction[moae_pkg::REGA_LSB +: moae_pkg::FIELD_W]
				== cmd.instruction[moae_pkg::REGB_LSB +: moae_pkg::FIELD_W];
			res_value_q  <= '0;
			res_stored_q <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= moae_pkg::STATUS_UNKNOWN;
			case (cmd.operation)
				moae_pkg::OP_WRITE: begin
					res_stored_q <= 1'b1;
					res_addr_q   <= cmd_maddr;
					res_status_q <= moae_pkg::STATUS_OK;
				end
				moae_pkg::OP_READ: res_status_q <= moae_pkg::STATUS_OK;
				default: ;
			endcase
		end
		if (state_q == S_RDB) begin
			b_q <= mem_rd_data;
		end
		if (alu_ctl.start) begin
			dz_q <= (alu_b == '0);
		end
		if (state_q == S_RDW) begin
			res_value_q <= mem_rd_data;
		end
		if ((state_q == S_RUN) && alu_done) begin
			res_value_q  <= alu_result;
			res_stored_q <= 1'b1;
			res_addr_q   <= dest_q;
			res_status_q <= ((opc_q == moae_pkg::OPC_DIV) && dz_q) ?
				moae_pkg::STATUS_DIV_ZERO : moae_pkg::STATUS_OK;
		end
		if (out_load) begin
			out_value_q  <= res_value_q;
			out_stored_q <= res_stored_q;
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_value  = out_value_q;
	assign rsp.stored        = out_stored_q;
	assign rsp.store_address = moae_pkg::ITEM_ADDR_W'(out_addr_q);
	assign rsp.status        = out_status_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("transfer in did not leave idle");

	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		alu_done |-> state_q == S_RUN)
		else $error("ALU finished outside run state");

	a_write_slots: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.wr_en |-> (state_q == S_IDLE || state_q == S_RUN))
		else $error("memory write outside a write slot");

	a_store_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stored_q) |-> out_status_q != moae_pkg::STATUS_UNKNOWN)
		else $error("store reported with unknown status");

	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		alu_ctl.start |=> !alu_ctl.start && state_q == S_RUN)
		else $error("ALU start not followed by run");

endmodule
`default_nettype wire
